[rtl/core/tapm_pkg.sv]
// ----------------------------------------------------------------------------
// tapm_pkg
// Shared types, constants and tables for the tone AM/PM/FM modulator core.
// ----------------------------------------------------------------------------
`default_nettype none

package tapm_pkg;

  // cordic
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned CORDIC_ITER  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned CORDIC_CNT_W = $clog2(ATAN_LEN);
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned ATAN_W       = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  // phase offset scaling
  localparam logic [29:0] TURNS_PER_RAD = 30'd683565276;

  // divider
  localparam int unsigned DIVIDEND_W = 38;
  localparam int unsigned DIVISOR_W  = 17;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // shared multiplier
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // register reset values
  localparam logic [31:0] MSG_STEP_RST = 32'd2863312;
  localparam logic [31:0] CAR_STEP_RST = 32'd14316558;
  localparam logic [15:0] GAIN_RST     = 16'd128;
  localparam logic [16:0] MSG_FREQ_RST = 17'd100;
  localparam logic [15:0] SMP_CNT_RST  = 16'd15000;

  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_MSG_STEP = 3'd1,
    CFG_CAR_STEP = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_MSG_FREQ = 3'd4,
    CFG_SMP_CNT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_AM   = 2'd0,
    MODE_PM   = 2'd1,
    MODE_FM   = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    logic              done;
    logic signed [15:0] cos_val;
    logic signed [15:0] sin_val;
  } cordic_res_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
  } div_res_t;

  function automatic logic [ATAN_W-1:0] atan_turn(input logic [CORDIC_CNT_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tapm_cordic.sv]
// ----------------------------------------------------------------------------
// tapm_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving
// rounded and saturated Q1.15 cosine and sine of a 32-bit turn angle.
// ----------------------------------------------------------------------------
`default_nettype none

module tapm_cordic (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire  [31:0]          angle_i,
  output tapm_pkg::cordic_res_t res_o
);

  localparam int unsigned W = tapm_pkg::CORDIC_W;

  logic signed [W-1:0] x_q, y_q, z_q;
  logic signed [W-1:0] x_d, y_d, z_d;
  logic                neg_q, neg_d;
  logic [tapm_pkg::CORDIC_CNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic signed [W-1:0] z0, z0_fold;
  logic                z0_neg;
  logic signed [W-1:0] dx, dy, atan_v;
  logic signed [W-1:0] xr, yr, xs, ys;

  function automatic logic signed [15:0] sat16(input logic signed [W-1:0] v);
    logic signed [15:0] r;
    if (v[W-1:15] == '0 || v[W-1:15] == '1) r = v[15:0];
    else if (v[W-1])                         r = 16'sh8000;
    else                                     r = 16'sh7fff;
    return r;
  endfunction

  always_comb begin
    z0      = W'(signed'(angle_i));
    z0_fold = z0;
    z0_neg  = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0_fold = z0 - 34'sd2147483648;
      z0_neg  = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0_fold = z0 + 34'sd2147483648;
      z0_neg  = 1'b1;
    end
  end

  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_v = signed'({{(W - tapm_pkg::ATAN_W){1'b0}}, tapm_pkg::atan_turn(cnt_q)});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = tapm_pkg::CORDIC_X0;
      y_d    = '0;
      z_d    = z0_fold;
      neg_d  = z0_neg;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_v;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tapm_pkg::CORDIC_CNT_W'(tapm_pkg::CORDIC_ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  // unfold, round and saturate
  assign xr = (neg_q ? -x_q : x_q) + 34'sd16384;
  assign yr = (neg_q ? -y_q : y_q) + 34'sd16384;
  assign xs = xr >>> 15;
  assign ys = yr >>> 15;

  assign res_o.done    = done_q;
  assign res_o.cos_val = sat16(xs);
  assign res_o.sin_val = sat16(ys);

endmodule

`default_nettype wire

[rtl/core/tapm_div.sv]
// ----------------------------------------------------------------------------
// tapm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tapm_div (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  [tapm_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire  [tapm_pkg::DIVISOR_W-1:0]    divisor_i,
  output tapm_pkg::div_res_t                res_o
);

  localparam int unsigned NW = tapm_pkg::DIVIDEND_W;
  localparam int unsigned DW = tapm_pkg::DIVISOR_W;

  logic [NW-1:0] dq_q, dq_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;
  logic [tapm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, dq_q[NW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
      dq_d  = {dq_q[NW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tapm_pkg::DIV_CNT_W'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dq_q;

endmodule

`default_nettype wire

[rtl/core/tone_am_pm_fm_modulator_core.sv]
// ----------------------------------------------------------------------------
// tone_am_pm_fm_modulator_core
// Flow: message CORDIC first; AM then runs the carrier CORDIC beside the gain
// multiply and ends with the AM multiply, PM/FM run gain, scale and divider
// before the carrier CORDIC, the unused mode goes straight to the output.
// A new request waits for idle, longer while the previous result stalls.
// Reset: async active low; phases and index clear, registers take defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_am_pm_fm_modulator_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // fields from bit 0: restart
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,
  // fields from bit 0: message_sample[15:0], modulated_sample[39:16]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MSG   = 9'b000000010,
    ST_GAIN  = 9'b000000100,
    ST_SCALE = 9'b000001000,
    ST_DIVST = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_CAR   = 9'b001000000,
    ST_AMMUL = 9'b010000000,
    ST_OUT   = 9'b100000000
  } st_e;

  st_e state_q, state_d;

  // configuration
  tapm_pkg::mode_e mode_q;
  logic [31:0] msg_step_q, car_step_q;
  logic [15:0] gain_q;
  logic [16:0] msg_freq_q;
  logic [15:0] smp_cnt_q;

  // sample state
  logic [31:0] msg_ph_q, car_ph_q;
  logic [15:0] idx_q;

  // datapath
  logic signed [15:0]                    m_q, c_q;
  logic signed [tapm_pkg::PROD_W-1:0]    prod_q;
  logic                                  neg_q;
  logic signed [tapm_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [tapm_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [tapm_pkg::PROD_W-1:0]    mag;
  logic [31:0]                           off;
  logic signed [23:0]                    mod_val;
  logic signed [tapm_pkg::PROD_W-1:0]    am_round;

  logic in_acc, out_free, last;

  logic                  cordic_start;
  logic [31:0]           cordic_angle;
  tapm_pkg::cordic_res_t cordic_res;
  logic                  div_start;
  logic [tapm_pkg::DIVISOR_W-1:0] div_divisor;
  tapm_pkg::div_res_t    div_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last          = (idx_q == (smp_cnt_q - 16'd1));

  // sequencer
  always_comb begin
    state_d      = state_q;
    cordic_start = 1'b0;
    cordic_angle = msg_ph_q;
    div_start    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cordic_start = 1'b1;
          cordic_angle = s_axis_tdata[0] ? 32'd0 : msg_ph_q;
          state_d      = ST_MSG;
        end
      end
      ST_MSG: begin
        if (cordic_res.done) begin
          case (mode_q)
            tapm_pkg::MODE_AM: begin
              cordic_start = 1'b1;
              cordic_angle = car_ph_q;
              state_d      = ST_GAIN;
            end
            tapm_pkg::MODE_PM, tapm_pkg::MODE_FM: state_d = ST_GAIN;
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_GAIN:  state_d = (mode_q == tapm_pkg::MODE_AM) ? ST_CAR : ST_SCALE;
      ST_SCALE: state_d = ST_DIVST;
      ST_DIVST: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          cordic_start = 1'b1;
          cordic_angle = car_ph_q + off;
          state_d      = ST_CAR;
        end
      end
      ST_CAR: begin
        if (cordic_res.done) begin
          state_d = (mode_q == tapm_pkg::MODE_AM) ? ST_AMMUL : ST_OUT;
        end
      end
      ST_AMMUL: state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GAIN: begin
        mul_a = signed'({17'd0, gain_q});
        if (mode_q == tapm_pkg::MODE_AM) mul_b = signed'({15'd0, ~m_q[15], m_q[14:0]});
        else                             mul_b = tapm_pkg::MUL_B_W'(m_q);
      end
      ST_SCALE: begin
        mul_a = prod_q[tapm_pkg::MUL_A_W-1:0];
        mul_b = signed'({1'b0, tapm_pkg::TURNS_PER_RAD});
      end
      ST_AMMUL: begin
        mul_a = signed'({1'b0, prod_q[31:0]});
        mul_b = tapm_pkg::MUL_B_W'(c_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mag         = prod_q[tapm_pkg::PROD_W-1] ? -prod_q : prod_q;
  assign div_divisor = (mode_q == tapm_pkg::MODE_FM && msg_freq_q != '0) ? msg_freq_q
                                                                          : 17'd1;
  assign off         = neg_q ? (32'd0 - div_res.quot[31:0]) : div_res.quot[31:0];
  assign am_round    = (prod_q + 64'sd8388608) >>> 24;

  always_comb begin
    case (mode_q)
      tapm_pkg::MODE_AM: begin
        if (am_round[63:23] == '0 || am_round[63:23] == '1) mod_val = am_round[23:0];
        else if (am_round[63])                              mod_val = 24'sh800000;
        else                                                mod_val = 24'sh7fffff;
      end
      tapm_pkg::MODE_PM, tapm_pkg::MODE_FM: mod_val = {{9{c_q[15]}}, c_q[15:1]};
      default: mod_val = '0;
    endcase
  end

  tapm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_angle),
    .res_o   (cordic_res)
  );

  tapm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag[tapm_pkg::DIVIDEND_W+22:23]),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  // control, configuration and sample state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= tapm_pkg::MODE_AM;
      msg_step_q    <= tapm_pkg::MSG_STEP_RST;
      car_step_q    <= tapm_pkg::CAR_STEP_RST;
      gain_q        <= tapm_pkg::GAIN_RST;
      msg_freq_q    <= tapm_pkg::MSG_FREQ_RST;
      smp_cnt_q     <= tapm_pkg::SMP_CNT_RST;
      msg_ph_q      <= '0;
      car_ph_q      <= '0;
      idx_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tapm_pkg::CFG_MODE:     mode_q     <= tapm_pkg::mode_e'(cfg_data_i[1:0]);
          tapm_pkg::CFG_MSG_STEP: msg_step_q <= cfg_data_i;
          tapm_pkg::CFG_CAR_STEP: car_step_q <= cfg_data_i;
          tapm_pkg::CFG_GAIN:     gain_q     <= cfg_data_i[15:0];
          tapm_pkg::CFG_MSG_FREQ: msg_freq_q <= cfg_data_i[16:0];
          tapm_pkg::CFG_SMP_CNT:  smp_cnt_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_acc && s_axis_tdata[0]) begin
        msg_ph_q <= '0;
        car_ph_q <= '0;
        idx_q    <= '0;
      end
      if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT) m_axis_tvalid <= 1'b0;
      if (state_q == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
        if (last) begin
          msg_ph_q <= '0;
          car_ph_q <= '0;
          idx_q    <= '0;
        end else begin
          msg_ph_q <= msg_ph_q + msg_step_q;
          car_ph_q <= car_ph_q + car_step_q;
          idx_q    <= idx_q + 16'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MSG && cordic_res.done) m_q <= cordic_res.sin_val;
    if (state_q == ST_CAR && cordic_res.done) c_q <= cordic_res.cos_val;
    if (state_q == ST_GAIN || state_q == ST_SCALE || state_q == ST_AMMUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_DIVST) neg_q <= prod_q[tapm_pkg::PROD_W-1];
    if (state_q == ST_OUT && out_free) begin
      m_axis_tdata <= {mod_val, m_q};
      m_axis_tlast <= last;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tapm_checker.sv]
// ----------------------------------------------------------------------------
// tapm_checker
// Port-level checks for the modulator core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module tapm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while a request is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after request");

endmodule

bind tone_am_pm_fm_modulator_core tapm_checker u_tapm_checker (.*);

`default_nettype wire
